/* rtl/core/acr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acr_pkg: shared types and constants of the associative replacement cache
// Operation codes, policy codes, register indexes, field widths and the
// command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package acr_pkg;

  localparam int OP_W        = 2;
  localparam int KEY_W       = 32;
  localparam int PAY_FIELD_W = 64;
  localparam int SLOT_W      = 4;
  localparam int STAMP_W     = 32;
  localparam int LFSR_W      = 16;
  localparam int POLICY_W    = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  // two remainder steps: quotient, then remainder
  localparam int MOD_CNT_W   = 1;

  // key, payload_in
  localparam int S_TDATA_W = KEY_W + PAY_FIELD_W;
  // hit, slot, payload_out, replaced, padded to whole bytes
  localparam int M_FIELDS_W = 1 + SLOT_W + PAY_FIELD_W + 1;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [POLICY_W-1:0] POL_FIFO   = 2'd0;
  localparam logic [POLICY_W-1:0] POL_RANDOM = 2'd1;
  localparam logic [POLICY_W-1:0] POL_LRU    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 1'b1;

  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
  localparam logic [LFSR_W-1:0] SEED_RESET = 16'd1;

  typedef struct packed {
    logic capture;   // take a new input transfer
    logic exec;      // evaluate the captured operation
    logic mod_step;  // one remainder step of the random victim
    logic scan_step; // one stamp compare of the LRU scan
    logic write;     // write the selected victim
    logic load_out;  // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic need_mod;
    logic need_scan;
    logic mod_last;
    logic scan_last;
    logic out_free;
  } status_t;

  // Galois step, x^16+x^14+x^13+x^11+1
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] cur);
    logic [LFSR_W-1:0] shifted;
    shifted = cur >> 1;
    return cur[0] ? (shifted ^ LFSR_TAPS) : shifted;
  endfunction

  // a zero seed would lock the generator up
  function automatic logic [LFSR_W-1:0] seed_fix(input logic [LFSR_W-1:0] seed);
    return (seed == '0) ? SEED_RESET : seed;
  endfunction

endpackage

/* rtl/core/acr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acr_ctrl: sequencing state machine
// Accepts one operation at a time, runs the victim search when needed and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module acr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  acr_pkg::status_t status,
  output acr_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOD,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    s_tready = (state == ST_IDLE) || ((state == ST_DONE) && status.out_free);
  end

  always_comb begin
    cmd           = '0;
    cmd.capture   = s_tvalid && s_tready;
    cmd.exec      = (state == ST_EXEC);
    cmd.mod_step  = (state == ST_MOD);
    cmd.scan_step = (state == ST_SCAN);
    cmd.write     = (state == ST_WRITE);
    cmd.load_out  = (state == ST_DONE) && status.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.need_mod)       state_next = ST_MOD;
        else if (status.need_scan) state_next = ST_SCAN;
        else                       state_next = ST_DONE;
      end
      ST_MOD: begin
        if (status.mod_last) state_next = ST_WRITE;
      end
      ST_SCAN: begin
        if (status.scan_last) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_next = s_tvalid ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/acr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acr_datapath: entry storage, victim selection and result register
// Holds valid bits, keys, payload and stamp memories, the FIFO pointer,
// the access counter, the LFSR and the configuration registers.
// ----------------------------------------------------------------------------
module acr_datapath #(
  parameter int SLOTS        = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  acr_pkg::cmd_t                       cmd,
  output acr_pkg::status_t                    status,
  input  logic [acr_pkg::S_TDATA_W-1:0]       s_tdata,
  input  logic [acr_pkg::OP_W-1:0]            s_tuser,
  input  logic                                cfg_valid,
  input  logic [acr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [acr_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [acr_pkg::M_TDATA_W-1:0]       m_tdata
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW:0] SLOTS_EXT = (IW + 1)'(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  // reciprocal of SLOTS, exact for every 16-bit dividend
  localparam int RECIP_SH = acr_pkg::LFSR_W + IW;
  localparam int RECIP_W  = acr_pkg::LFSR_W + 2;
  localparam int PROD_W   = acr_pkg::LFSR_W + RECIP_W;
  localparam longint RECIP_FULL = ((longint'(1) << RECIP_SH) + longint'(SLOTS)
                                   - longint'(1)) / longint'(SLOTS);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  // configuration
  logic [acr_pkg::POLICY_W-1:0] policy;
  logic [acr_pkg::LFSR_W-1:0]   seed;

  // captured operation
  logic [acr_pkg::OP_W-1:0]  op;
  logic [acr_pkg::KEY_W-1:0] key;
  logic [PAYLOAD_BITS-1:0]   pay_in;

  // entry state
  logic [SLOTS-1:0]             valid;
  logic [acr_pkg::KEY_W-1:0]    keys [SLOTS];
  logic [PAYLOAD_BITS-1:0]      pay_mem [SLOTS];
  logic [acr_pkg::STAMP_W-1:0]  stamp_mem [SLOTS];
  logic [PAYLOAD_BITS-1:0]      pay_rd;
  logic [acr_pkg::STAMP_W-1:0]  stamp_rd;
  logic [IW-1:0]                fifo_ptr;
  logic [acr_pkg::STAMP_W-1:0]  access_count;
  logic [acr_pkg::LFSR_W-1:0]   lfsr;

  // victim search
  logic [IW-1:0]                 mod_rem;
  logic [acr_pkg::LFSR_W-1:0]    mod_div;
  logic [acr_pkg::LFSR_W-1:0]    mod_quo;
  logic [acr_pkg::MOD_CNT_W-1:0] mod_cnt;
  logic [IW-1:0]                 scan_idx;
  logic [IW-1:0]                 best_idx;
  logic [acr_pkg::STAMP_W-1:0]   best_stamp;

  // result
  logic                         res_hit;
  logic [acr_pkg::SLOT_W-1:0]   res_slot;
  logic                         res_replaced;

  // combinational
  logic                         is_lookup;
  logic                         is_insert;
  logic                         is_clear;
  logic                         full;
  logic                         hit_any;
  logic [IW-1:0]                hit_idx;
  logic [IW-1:0]                free_idx;
  logic                         ins_now;
  logic                         ins_en;
  logic                         touch;
  logic                         fifo_adv;
  logic [IW-1:0]                wr_idx;
  logic [IW-1:0]                stamp_wr_idx;
  logic [acr_pkg::STAMP_W-1:0]  new_count;
  logic [acr_pkg::LFSR_W-1:0]   lfsr_stepped;
  logic [PROD_W-1:0]            mod_prod;
  logic [acr_pkg::LFSR_W-1:0]   mod_quo_next;
  logic [acr_pkg::LFSR_W-1:0]   mod_back;
  logic [IW-1:0]                mod_rem_next;
  logic                         stamp_rd_en;
  logic [IW-1:0]                stamp_rd_addr;
  logic [IW:0]                  fifo_inc;
  logic [IW+acr_pkg::SLOT_W-1:0] slot_ext;

  // low slot-field bits of a slot number
  function automatic logic [acr_pkg::SLOT_W-1:0] slot_ext_of_hit(input logic [IW-1:0] idx);
    logic [IW+acr_pkg::SLOT_W-1:0] ext;
    ext = (IW + acr_pkg::SLOT_W)'(idx);
    return ext[acr_pkg::SLOT_W-1:0];
  endfunction

  assign is_lookup = (op == acr_pkg::OP_LOOKUP);
  assign is_insert = (op == acr_pkg::OP_INSERT);
  assign is_clear  = (op == acr_pkg::OP_CLEAR);
  assign full      = &valid;

  // lowest matching valid slot and lowest free slot
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (valid[i] && (keys[i] == key)) begin
        hit_any = 1'b1;
        hit_idx = IW'(i);
      end
      if (!valid[i]) free_idx = IW'(i);
    end
  end

  always_comb begin
    status.need_mod  = is_insert && full && (policy == acr_pkg::POL_RANDOM);
    status.need_scan = is_insert && full && (policy != acr_pkg::POL_RANDOM)
                       && (policy != acr_pkg::POL_FIFO);
    status.mod_last  = &mod_cnt;
    status.scan_last = (scan_idx == LAST_IDX);
    status.out_free  = !m_tvalid || m_tready;
  end

  assign ins_now  = cmd.exec && is_insert && !status.need_mod && !status.need_scan;
  assign ins_en   = ins_now || cmd.write;
  assign touch    = (cmd.exec && is_lookup && hit_any) || ins_en;
  assign fifo_adv = ins_now && full;
  assign fifo_inc = {1'b0, fifo_ptr} + (IW + 1)'(1);

  always_comb begin
    if (cmd.write) begin
      wr_idx = (policy == acr_pkg::POL_RANDOM) ? mod_rem : best_idx;
    end else begin
      wr_idx = full ? fifo_ptr : free_idx;
    end
  end

  assign stamp_wr_idx = ins_en ? wr_idx : hit_idx;
  assign new_count    = (access_count == '1) ? access_count
                                             : access_count + acr_pkg::STAMP_W'(1);
  assign lfsr_stepped = acr_pkg::lfsr_next(lfsr);
  assign slot_ext     = (IW + acr_pkg::SLOT_W)'(wr_idx);

  // remainder by reciprocal multiplication: quotient in the first step,
  // remainder from the low bits in the second
  assign mod_prod     = PROD_W'(mod_div) * PROD_W'(RECIP);
  assign mod_quo_next = acr_pkg::LFSR_W'(mod_prod >> RECIP_SH);
  assign mod_back     = mod_quo * acr_pkg::LFSR_W'(SLOTS);
  assign mod_rem_next = mod_div[IW-1:0] - mod_back[IW-1:0];

  assign stamp_rd_en   = (cmd.exec && status.need_scan)
                         || (cmd.scan_step && !status.scan_last);
  assign stamp_rd_addr = cmd.exec ? '0 : scan_idx + IW'(1);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      policy       <= acr_pkg::POL_FIFO;
      seed         <= acr_pkg::SEED_RESET;
      valid        <= '0;
      fifo_ptr     <= '0;
      access_count <= '0;
      lfsr         <= acr_pkg::SEED_RESET;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          acr_pkg::CFG_POLICY: policy <= cfg_data[acr_pkg::POLICY_W-1:0];
          acr_pkg::CFG_SEED:   seed   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.exec && is_clear) begin
        valid    <= '0;
        fifo_ptr <= '0;
        lfsr     <= acr_pkg::seed_fix(seed);
      end
      if (ins_en) valid[wr_idx] <= 1'b1;
      if (fifo_adv) fifo_ptr <= (fifo_inc == SLOTS_EXT) ? '0 : fifo_inc[IW-1:0];
      if (cmd.exec && status.need_mod) lfsr <= lfsr_stepped;
      if (touch) access_count <= new_count;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // operand capture, memories, search and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op     <= s_tuser;
      key    <= s_tdata[acr_pkg::KEY_W-1:0];
      pay_in <= s_tdata[acr_pkg::KEY_W +: PAYLOAD_BITS];
    end
    if (ins_en) begin
      keys[wr_idx]    <= key;
      pay_mem[wr_idx] <= pay_in;
    end
    if (touch) stamp_mem[stamp_wr_idx] <= new_count;
    if (cmd.exec && is_lookup && hit_any) pay_rd <= pay_mem[hit_idx];
    if (stamp_rd_en) stamp_rd <= stamp_mem[stamp_rd_addr];

    if (cmd.exec && status.need_mod) begin
      mod_div <= lfsr_stepped;
      mod_cnt <= '0;
    end else if (cmd.mod_step) begin
      if (mod_cnt == '0) begin
        mod_quo <= mod_quo_next;
      end else begin
        mod_rem <= mod_rem_next;
      end
      mod_cnt <= mod_cnt + acr_pkg::MOD_CNT_W'(1);
    end

    if (cmd.exec && status.need_scan) begin
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      if ((scan_idx == '0) || (stamp_rd < best_stamp)) begin
        best_stamp <= stamp_rd;
        best_idx   <= scan_idx;
      end
      scan_idx <= scan_idx + IW'(1);
    end

    if (cmd.exec) begin
      res_hit      <= is_lookup && hit_any;
      res_replaced <= ins_now && full;
      if (is_lookup && hit_any) begin
        res_slot <= slot_ext_of_hit(hit_idx);
      end else if (ins_now) begin
        res_slot <= slot_ext[acr_pkg::SLOT_W-1:0];
      end else begin
        res_slot <= '0;
      end
    end else if (cmd.write) begin
      res_hit      <= 1'b0;
      res_replaced <= 1'b1;
      res_slot     <= slot_ext[acr_pkg::SLOT_W-1:0];
    end

    if (cmd.load_out) begin
      m_tdata <= {(acr_pkg::M_TDATA_W - acr_pkg::M_FIELDS_W)'(0), res_replaced,
                  res_hit ? acr_pkg::PAY_FIELD_W'(pay_rd) : acr_pkg::PAY_FIELD_W'(0),
                  res_slot, res_hit};
    end
  end

endmodule

/* rtl/core/assoc_cache_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assoc_cache_replacement: fully associative keyed store with replacement
// Lookup, insert and clear over SLOTS entries; FIFO, random or LRU victims.
// ----------------------------------------------------------------------------
// Sequence: after the input transfer, EXEC then DONE for lookup, clear, unused
//   codes, fill inserts and FIFO replacement; EXEC, MOD, WRITE, DONE for random
//   replacement (two-step reciprocal remainder unit); EXEC, SCAN, WRITE, DONE for
//   LRU replacement (one stamp memory read per cycle). DONE holds on a busy output.
// Flow: one operation in flight; the next is taken as DONE hands the result over.
// Reset: synchronous; all entries invalid at once, no clearing pass.
module assoc_cache_replacement #(
  parameter int SLOTS        = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // operation stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [acr_pkg::S_TDATA_W-1:0]       s_tdata,  // key[31:0], payload_in[95:32]
  input  logic [acr_pkg::OP_W-1:0]            s_tuser,  // op[1:0]
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [acr_pkg::M_TDATA_W-1:0]       m_tdata,  // hit[0], slot[4:1],
                                                        // payload_out[68:5], replaced[69]
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [acr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [acr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  acr_pkg::cmd_t    cmd;
  acr_pkg::status_t status;

  // Register writes are stored at the clock edge of the transfer; every transfer is taken.
  assign cfg_ready = 1'b1;

  // Controller: accept an operation, step through the victim search when an insert
  // meets a full store under a non-FIFO policy, then transfer the result into the
  // output register. A new operation is taken in the cycle the result is handed over.
  acr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: parallel key compare across all slots, lowest-slot priority,
  // payload and stamp memories, the random remainder unit, the LRU stamp
  // scan and the output register that decouples the result side.
  acr_datapath #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

/* bench/tb_assoc_cache_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_assoc_cache_replacement: self-checking bench for the replacement cache
// Drives lookup, insert, clear and unused operations through the input stream
// and writes policy and seed registers between phases. An in-bench cache
// model predicts every result, and a monitor compares each result transfer,
// field by field, with the oldest prediction. Both stream sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb_assoc_cache_replacement;
  import acr_pkg::*;

  localparam int NUM_SLOTS     = 16;
  localparam int CYCLE_LIMIT   = 1_000_000;
  // slowest replacement (LRU) bounds the settle time; leave margin
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_OPS     = 232;
  localparam int MAX_REPORTS   = 10;

  // codes with no name in the package, and a copy of the LFSR taps
  localparam logic [OP_W-1:0]     OP_UNUSED    = 2'd3;
  localparam logic [POLICY_W-1:0] POL_LRU_ALT  = 2'd3;
  localparam logic [LFSR_W-1:0]   GALOIS_TAPS  = 16'hB400;

  // one result, laid out as in m_tdata from bit 0 up
  typedef struct packed {
    logic                   replaced;
    logic [PAY_FIELD_W-1:0] payload;
    logic [SLOT_W-1:0]      slot;
    logic                   hit;
  } outcome_t;

  logic clk;
  logic rst = 1'b1;

  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata   = '0;  // key[31:0], payload_in[95:32]
  logic [OP_W-1:0]        s_tuser   = '0;  // op[1:0]
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;         // hit[0], slot[4:1], payload_out[68:5],
                                           // replaced[69]
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  assoc_cache_replacement #(
    .SLOTS        (NUM_SLOTS),
    .PAYLOAD_BITS (PAY_FIELD_W)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Cache model: a private copy of the store, pointers and registers
  // --------------------------------------------------------------------------
  logic                   model_valid [NUM_SLOTS];
  logic [KEY_W-1:0]       model_key   [NUM_SLOTS];
  logic [PAY_FIELD_W-1:0] model_pay   [NUM_SLOTS];
  logic [STAMP_W-1:0]     model_stamp [NUM_SLOTS];
  logic [SLOT_W-1:0]      model_fifo_ptr;
  logic [STAMP_W-1:0]     model_access;
  logic [LFSR_W-1:0]      model_lfsr;
  logic [POLICY_W-1:0]    model_policy;
  logic [LFSR_W-1:0]      model_seed;

  outcome_t pending_outcomes [$];

  // run statistics
  int sent_count     = 0;
  int checked_count  = 0;
  int hit_count      = 0;
  int clear_count    = 0;
  int evict_count [4] = '{0, 0, 0, 0};
  int mismatch_count = 0;
  int cycle_count    = 0;

  // sender and receiver idling switches, changed per phase
  bit tx_gaps_on   = 1'b1;
  bit rx_stalls_on = 1'b1;

  logic [KEY_W-1:0] key_pool [24];

  function automatic void reload_lfsr();
    // a zero seed would freeze the generator
    model_lfsr = (model_seed == '0) ? 16'd1 : model_seed;
  endfunction

  function automatic logic [STAMP_W-1:0] bump_access();
    if (model_access != '1) model_access = model_access + STAMP_W'(1);
    return model_access;
  endfunction

  function automatic void reset_cache_model();
    foreach (model_valid[i]) begin
      model_valid[i] = 1'b0;
      model_key[i]   = '0;
      model_pay[i]   = '0;
      model_stamp[i] = '0;
    end
    model_fifo_ptr = '0;
    model_access   = '0;
    model_policy   = POL_FIFO;
    model_seed     = 16'd1;
    reload_lfsr();
  endfunction

  // apply one operation to the model and return the result it produces
  function automatic outcome_t cache_outcome(input logic [OP_W-1:0] op,
                                             input logic [KEY_W-1:0] key,
                                             input logic [PAY_FIELD_W-1:0] pay);
    outcome_t res;
    int       victim;
    bit       found;
    res    = '0;
    victim = 0;
    found  = 1'b0;
    case (op)
      OP_LOOKUP: begin
        // lowest matching valid slot wins; a hit refreshes its stamp
        for (int i = 0; i < NUM_SLOTS && !found; i++) begin
          if (model_valid[i] && model_key[i] == key) begin
            found          = 1'b1;
            res.hit        = 1'b1;
            res.slot       = i[SLOT_W-1:0];
            res.payload    = model_pay[i];
            model_stamp[i] = bump_access();
          end
        end
        if (found) hit_count++;
      end
      OP_INSERT: begin
        // fill the lowest free slot first; no duplicate check
        for (int i = 0; i < NUM_SLOTS && !found; i++) begin
          if (!model_valid[i]) begin
            found  = 1'b1;
            victim = i;
          end
        end
        if (!found) begin
          res.replaced = 1'b1;
          evict_count[model_policy]++;
          case (model_policy)
            POL_FIFO: begin
              victim         = int'(model_fifo_ptr);
              model_fifo_ptr = model_fifo_ptr + SLOT_W'(1);
            end
            POL_RANDOM: begin
              // Galois step first, then take the low bits
              model_lfsr = model_lfsr[0] ? ((model_lfsr >> 1) ^ GALOIS_TAPS)
                                         : (model_lfsr >> 1);
              victim     = int'(model_lfsr[SLOT_W-1:0]);
            end
            default: begin
              // least recent stamp, ties to the lowest slot
              victim = 0;
              for (int i = 1; i < NUM_SLOTS; i++)
                if (model_stamp[i] < model_stamp[victim]) victim = i;
            end
          endcase
        end
        model_valid[victim] = 1'b1;
        model_key[victim]   = key;
        model_pay[victim]   = pay;
        model_stamp[victim] = bump_access();
        res.slot            = victim[SLOT_W-1:0];
      end
      OP_CLEAR: begin
        // access counter and stored keys survive a clear
        foreach (model_valid[i]) model_valid[i] = 1'b0;
        model_fifo_ptr = '0;
        reload_lfsr();
        clear_count++;
      end
      default: ;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // send one operation; leave tvalid high so the next one can follow at once
  task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [PAY_FIELD_W-1:0] pay);
    int gap;
    gap = pick_gap(tx_gaps_on);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {pay, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // transfer taken at this edge: predict now
    pending_outcomes.push_back(cache_outcome(op, key, pay));
    sent_count++;
  endtask

  // hold the sender until every predicted result has been checked
  task automatic wait_for_idle();
    s_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    wait_for_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_POLICY) model_policy = data[POLICY_W-1:0];
    else                   model_seed   = data[LFSR_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [PAY_FIELD_W-1:0] random_payload();
    int r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // lookup on an empty store misses; the unused op does nothing
  task automatic test_empty_and_unused();
    send_op(OP_LOOKUP, '0, '0);
    send_op(OP_UNUSED, '1, '1);
  endtask

  // extreme keys and payloads, duplicate insert, lookup after clear
  task automatic test_duplicates_and_clear();
    send_op(OP_INSERT, '0, '0);
    send_op(OP_INSERT, '1, '1);
    send_op(OP_INSERT, '1, 64'h5555_AAAA_0F0F_F0F0);  // duplicate key, higher slot
    send_op(OP_LOOKUP, '1, '0);                       // must report the lower slot
    send_op(OP_LOOKUP, '0, '1);
    send_op(OP_CLEAR,  '0, '0);
    send_op(OP_LOOKUP, '1, '0);
  endtask

  // fill all slots, then force a FIFO eviction of slot 0
  task automatic test_fill_and_evict();
    logic [KEY_W-1:0] key;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      key = (i == 0) ? 32'h0 : (i == NUM_SLOTS - 1) ? 32'hFFFF_FFFF : 32'hA5A5_0000 + i;
      send_op(OP_INSERT, key, {$urandom, $urandom});
    end
    send_op(OP_INSERT, 32'h5A5A_5A5A, {$urandom, $urandom});
    send_op(OP_LOOKUP, 32'h0, '0);
  endtask

  // one register setting, then a stream of random operations on a key pool
  // small enough that hits, duplicates and evictions are frequent
  task automatic test_random_phase(input int phase, input logic [POLICY_W-1:0] pol,
                                   input logic [LFSR_W-1:0] seed, input bit clear_now);
    int               r;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    write_register(CFG_POLICY, {{(CFG_DATA_W-POLICY_W){1'b0}}, pol});
    write_register(CFG_SEED, seed);
    tx_gaps_on   = (phase % 3 != 1);
    rx_stalls_on = (phase % 3 != 2);
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    // without a clear the new seed waits for the next clear in the stream
    if (clear_now) send_op(OP_CLEAR, $urandom, random_payload());
    for (int n = 0; n < PHASE_OPS; n++) begin
      r = $urandom_range(999);
      if (r < 460)      op = OP_LOOKUP;
      else if (r < 950) op = OP_INSERT;
      else if (r < 965) op = OP_CLEAR;
      else              op = OP_UNUSED;
      key = ($urandom_range(9) < 8) ? key_pool[$urandom_range(23)] : $urandom;
      send_op(op, key, random_payload());
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the checker
  // --------------------------------------------------------------------------
  initial begin
    int run;
    int gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!rx_stalls_on) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        run = $urandom_range(1, 6);
        m_tready <= 1'b1;
        repeat (run) @(posedge clk);
        gap = pick_gap(1'b1);
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = outcome_t'(m_tdata[M_FIELDS_W-1:0]);
      checked_count++;
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] unexpected result: hit=%0b slot=%0d payload=%h replaced=%0b",
                   $realtime, got.hit, got.slot, got.payload, got.replaced);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.hit !== want.hit || got.slot !== want.slot ||
            got.payload !== want.payload || got.replaced !== want.replaced) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] result %0d mismatch", $realtime, checked_count);
            $display("  expected hit=%0b slot=%0d payload=%h replaced=%0b",
                     want.hit, want.slot, want.payload, want.replaced);
            $display("  actual   hit=%0b slot=%0d payload=%h replaced=%0b",
                     got.hit, got.slot, got.payload, got.replaced);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_outcomes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_cache_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_unused();
    test_duplicates_and_clear();
    test_fill_and_evict();

    // every policy code, seed extremes, and a seed change left pending
    test_random_phase(0, POL_FIFO,    16'($urandom_range(2, 65534)), 1'b1);
    test_random_phase(1, POL_RANDOM,  16'h0000, 1'b1);
    test_random_phase(2, POL_RANDOM,  16'hFFFF, 1'b1);
    test_random_phase(3, POL_LRU,     16'($urandom_range(2, 65534)), 1'b0);
    test_random_phase(4, POL_LRU_ALT, 16'($urandom_range(2, 65534)), 1'b1);
    test_random_phase(5, POL_RANDOM,  16'h0001, 1'b0);
    test_random_phase(6, POL_FIFO,    16'($urandom_range(2, 65534)), 1'b0);

    wait_for_idle();

    $display("%0d operations sent, %0d results checked, %0d lookup hits, %0d clears",
             sent_count, checked_count, hit_count, clear_count);
    $display("evictions: fifo %0d, random %0d, lru %0d, lru via code 3 %0d; mismatches %0d",
             evict_count[0], evict_count[1], evict_count[2], evict_count[3],
             mismatch_count);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
